### rtl/noe_pkg.sv
// shared types, constants and sine table for the note oscillator core
package noe_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SAMPLE_BITS     = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int INDEX_BITS      = 20;

  // fixed field widths
  localparam int STEP_BITS   = 31;
  localparam int ROW_BITS    = 20;
  localparam int SCALE_BITS  = 24;
  localparam int LEN16_BITS  = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int IN_FIELDS_W  = 1 + STEP_BITS + 2 + 1 + 1;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;

  // envelope in Q0.24, one extra bit to hold unity
  localparam int ENV_BITS = 24;
  localparam int ENV_W    = ENV_BITS + 1;
  localparam logic [ENV_W-1:0] ENV_ONE = {1'b1, {ENV_BITS{1'b0}}};

  // product widths in the back end
  localparam int IPROD_W = INDEX_BITS + SCALE_BITS;
  localparam int RPROD_W = ROW_BITS + SCALE_BITS;
  localparam int CMP_W   = ((INDEX_BITS > ROW_BITS) ? INDEX_BITS : ROW_BITS) + 1;

  localparam logic signed [SAMPLE_BITS-1:0] AMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] AMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // register reset values
  localparam logic [ROW_BITS-1:0]   RST_ROW_SAMPLES     = ROW_BITS'(22050);
  localparam logic [SCALE_BITS-1:0] RST_ROW_SCALE       = SCALE_BITS'(761);
  localparam logic [LEN16_BITS-1:0] RST_ATTACK_SAMPLES  = LEN16_BITS'(441);
  localparam logic [SCALE_BITS-1:0] RST_ATTACK_SCALE    = SCALE_BITS'(38044);
  localparam logic [LEN16_BITS-1:0] RST_RELEASE_SAMPLES = LEN16_BITS'(441);
  localparam logic [SCALE_BITS-1:0] RST_RELEASE_SCALE   = SCALE_BITS'(38044);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ROW_SAMPLES     = 3'd0,
    CFG_ROW_SCALE       = 3'd1,
    CFG_ATTACK_SAMPLES  = 3'd2,
    CFG_ATTACK_SCALE    = 3'd3,
    CFG_RELEASE_SAMPLES = 3'd4,
    CFG_RELEASE_SCALE   = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    WAVE_SINE  = 2'd0,
    WAVE_PULSE = 2'd1,
    WAVE_SAW   = 2'd2,
    WAVE_TRI   = 2'd3
  } wave_t;

  typedef struct packed {
    logic [ROW_BITS-1:0]   row_len;        // row_samples, zero read as one
    logic [SCALE_BITS-1:0] row_scale;
    logic [LEN16_BITS-1:0] attack_samples;
    logic [SCALE_BITS-1:0] attack_scale;
    logic [LEN16_BITS-1:0] release_samples;
    logic [SCALE_BITS-1:0] release_scale;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic [INDEX_BITS-1:0] index;
    wave_t                 waveform;
    logic                  is_rest;
    logic                  has_decay;
    logic                  row_end;
  } item_t;

  // quarter-wave sine table, entries 0 .. 2^SINE_TABLE_BITS inclusive
  localparam int SINE_ENTRIES = (1 << SINE_TABLE_BITS) + 1;
  localparam longint Q30 = 64'sd1073741824;

  typedef logic [SAMPLE_BITS-2:0] sine_val_t;
  typedef sine_val_t sine_lut_t [SINE_ENTRIES];

  function automatic longint sine_entry(input longint k);
    longint coef [6];
    longint x;
    longint x2;
    longint acc;
    longint amax;
    coef = '{-64'sd3864, 64'sd172272, -64'sd5026995,
             64'sd85569305, -64'sd693598342, 64'sd1686629713};
    amax = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    x    = k * (longint'(1) << (30 - SINE_TABLE_BITS));
    x2   = x * x / Q30;
    acc  = coef[0];
    for (int i = 1; i < 6; i++) begin
      acc = coef[i] + acc * x2 / Q30;
    end
    acc = acc * x / Q30;
    if (acc < 0) acc = 0;
    if (acc > Q30) acc = Q30;
    acc = (acc * amax + (Q30 / 2)) / Q30;
    if (acc > amax) acc = amax;
    return acc;
  endfunction

  function automatic sine_lut_t build_sine();
    sine_lut_t t;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      t[k] = sine_val_t'(sine_entry(longint'(k)));
    end
    return t;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine();

endpackage

### rtl/noe_front.sv
// front end: phase accumulator and sample index, tags each tick
module noe_front import noe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 push,
  input  logic                 start_row,
  input  logic [STEP_BITS-1:0] phase_step,
  input  wave_t                waveform,
  input  logic                 is_rest,
  input  logic                 has_decay,
  output item_t                item
);

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [INDEX_BITS-1:0] index_r, index_nxt;
  logic [PHASE_BITS-1:0] cur_phase;
  logic [INDEX_BITS-1:0] cur_index;
  logic [PHASE_BITS+31:0] step_wide;
  logic [PHASE_BITS-1:0] inc;
  logic                  last;

  // align the Q0.32 step to the accumulator width
  assign step_wide = (PHASE_BITS + 32)'({1'b0, phase_step}) << PHASE_BITS;
  assign inc       = step_wide[PHASE_BITS+31:32];

  always_comb begin
    cur_phase = start_row ? '0 : phase_r;
    cur_index = start_row ? '0 : index_r;
    last      = CMP_W'(cur_index) >= (CMP_W'(cfg.row_len) - CMP_W'(1));
    if (last) begin
      phase_nxt = '0;
      index_nxt = '0;
    end else begin
      phase_nxt = cur_phase + inc;
      index_nxt = cur_index + INDEX_BITS'(1);
    end
    item.phase     = cur_phase;
    item.index     = cur_index;
    item.waveform  = waveform;
    item.is_rest   = is_rest;
    item.has_decay = has_decay;
    item.row_end   = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      index_r <= '0;
    end else if (push) begin
      phase_r <= phase_nxt;
      index_r <= index_nxt;
    end
  end

endmodule

### rtl/noe_queue.sv
// small register queue between front and back end
module noe_queue import noe_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = count_r == QCNT_W'(QDEPTH);
  assign head_valid = count_r != '0;
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + QCNT_W'(1);
    if (pop && !push) count_nxt = count_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

### rtl/noe_back.sv
// back end: waveform, envelope and scaling pipeline with output register
module noe_back import noe_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          q_valid,
  input  item_t                         q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_last
);

  logic advance;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;

  // stage 1: products, compares, table read
  logic [IPROD_W-1:0]     ia_r, ia_nxt, id_r, id_nxt;
  logic [RPROD_W-1:0]     ir_r, ir_nxt;
  logic                   att_r, att_nxt, rel_r, rel_nxt, past_r, past_nxt;
  sine_val_t              rom_r, rom_nxt;
  logic [1:0]             quad_r, quad_nxt;
  logic signed [SAMPLE_BITS-1:0] saw_r, saw_nxt;
  wave_t                  wave1_r;
  logic                   rest1_r, decay1_r, last1_r;
  logic [SINE_TABLE_BITS+1:0] top_bits;
  logic [SINE_TABLE_BITS:0]   kidx;
  logic [CMP_W-1:0]       diff;
  logic [PHASE_BITS+SAMPLE_BITS-1:0] phase_wide;

  // stage 2: attack level, shaping factor, raw wave
  logic [ENV_W-1:0]       amp_a_r, amp_a_nxt, f_r, f_nxt;
  logic                   use_f_r, use_f_nxt;
  logic signed [SAMPLE_BITS-1:0] raw_r, raw_nxt;
  logic                   rest2_r, last2_r;
  logic [ENV_W-1:0]       fd, fr;
  logic [SAMPLE_BITS:0]   saw_abs, tri_w;

  // stage 3: envelope, magnitude and sign
  logic [ENV_W-1:0]       amp_r, amp_nxt;
  logic [SAMPLE_BITS-1:0] mag_r, mag_nxt;
  logic                   neg3_r, rest3_r, last3_r;
  logic [2*ENV_W-1:0]     env_prod;
  logic signed [SAMPLE_BITS:0] raw_ext;

  // stage 4: scaled magnitude
  logic [SAMPLE_BITS:0]   smag_r, smag_nxt;
  logic                   neg4_r, rest4_r, last4_r;
  logic [SAMPLE_BITS+ENV_W-1:0] out_prod;

  // output register
  logic signed [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic                   last_r;
  logic [SAMPLE_BITS:0]   neg_mag;

  assign advance = !out_valid_r || out_ready;
  assign q_pop   = advance && q_valid;

  always_comb begin
    ia_nxt   = IPROD_W'(q_item.index) * IPROD_W'(cfg.attack_scale);
    id_nxt   = IPROD_W'(q_item.index) * IPROD_W'(cfg.row_scale);
    diff     = CMP_W'(cfg.row_len) - CMP_W'(q_item.index);
    ir_nxt   = RPROD_W'(diff[ROW_BITS-1:0]) * RPROD_W'(cfg.release_scale);
    att_nxt  = CMP_W'(q_item.index) < CMP_W'(cfg.attack_samples);
    rel_nxt  = (CMP_W'(q_item.index) + CMP_W'(cfg.release_samples)) > CMP_W'(cfg.row_len);
    past_nxt = CMP_W'(q_item.index) >= CMP_W'(cfg.row_len);
    top_bits = q_item.phase[PHASE_BITS-1 -: SINE_TABLE_BITS+2];
    quad_nxt = top_bits[SINE_TABLE_BITS+1:SINE_TABLE_BITS];
    // odd quadrants run the table backwards
    kidx     = quad_nxt[0]
             ? ((SINE_TABLE_BITS+1)'(1) << SINE_TABLE_BITS)
               - (SINE_TABLE_BITS+1)'(top_bits[SINE_TABLE_BITS-1:0])
             : (SINE_TABLE_BITS+1)'(top_bits[SINE_TABLE_BITS-1:0]);
    rom_nxt  = SINE_LUT[kidx];
    phase_wide = {q_item.phase, {SAMPLE_BITS{1'b0}}};
    saw_nxt  = phase_wide[PHASE_BITS+SAMPLE_BITS-1 -: SAMPLE_BITS];
  end

  always_comb begin
    if (att_r) amp_a_nxt = (ia_r >= IPROD_W'(ENV_ONE)) ? ENV_ONE : ia_r[ENV_W-1:0];
    else       amp_a_nxt = ENV_ONE;
    fd        = (id_r >= IPROD_W'(ENV_ONE)) ? '0 : ENV_ONE - id_r[ENV_W-1:0];
    if (past_r)                          fr = '0;
    else if (ir_r >= RPROD_W'(ENV_ONE))  fr = ENV_ONE;
    else                                 fr = ir_r[ENV_W-1:0];
    f_nxt     = decay1_r ? fd : fr;
    use_f_nxt = decay1_r || rel_r;

    saw_abs = saw_r[SAMPLE_BITS-1] ? -(SAMPLE_BITS+1)'(saw_r) : (SAMPLE_BITS+1)'(saw_r);
    tri_w   = (saw_abs << 1) - ((SAMPLE_BITS+1)'(1) << (SAMPLE_BITS-1));
    unique case (wave1_r)
      WAVE_SINE:  raw_nxt = quad_r[1] ? -$signed({1'b0, rom_r}) : $signed({1'b0, rom_r});
      WAVE_PULSE: raw_nxt = ((rom_r != '0) && !quad_r[1]) ? AMP_MAX : -AMP_MAX;
      WAVE_SAW:   raw_nxt = saw_r;
      // full-scale negative saw folds to one past the top, clamp it
      WAVE_TRI:   raw_nxt = (saw_r == AMP_MIN) ? AMP_MAX : $signed(tri_w[SAMPLE_BITS-1:0]);
    endcase
  end

  always_comb begin
    env_prod = (2*ENV_W)'(amp_a_r) * (2*ENV_W)'(f_r);
    amp_nxt  = use_f_r ? env_prod[ENV_BITS +: ENV_W] : amp_a_r;
    raw_ext  = (SAMPLE_BITS+1)'(raw_r);
    mag_nxt  = raw_ext[SAMPLE_BITS] ? SAMPLE_BITS'(-raw_ext) : SAMPLE_BITS'(raw_ext);
  end

  always_comb begin
    out_prod = (SAMPLE_BITS+ENV_W)'(mag_r) * (SAMPLE_BITS+ENV_W)'(amp_r);
    smag_nxt = out_prod[ENV_BITS +: SAMPLE_BITS+1];
  end

  always_comb begin
    neg_mag = -smag_r;
    if (rest4_r)                               sample_nxt = '0;
    else if (neg4_r)                           sample_nxt = $signed(neg_mag[SAMPLE_BITS-1:0]);
    else if (smag_r > (SAMPLE_BITS+1)'(AMP_MAX)) sample_nxt = AMP_MAX;
    else                                       sample_nxt = $signed(smag_r[SAMPLE_BITS-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= q_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ia_r     <= ia_nxt;
      id_r     <= id_nxt;
      ir_r     <= ir_nxt;
      att_r    <= att_nxt;
      rel_r    <= rel_nxt;
      past_r   <= past_nxt;
      rom_r    <= rom_nxt;
      quad_r   <= quad_nxt;
      saw_r    <= saw_nxt;
      wave1_r  <= q_item.waveform;
      rest1_r  <= q_item.is_rest;
      decay1_r <= q_item.has_decay;
      last1_r  <= q_item.row_end;

      amp_a_r  <= amp_a_nxt;
      f_r      <= f_nxt;
      use_f_r  <= use_f_nxt;
      raw_r    <= raw_nxt;
      rest2_r  <= rest1_r;
      last2_r  <= last1_r;

      amp_r    <= amp_nxt;
      mag_r    <= mag_nxt;
      neg3_r   <= raw_r[SAMPLE_BITS-1];
      rest3_r  <= rest2_r;
      last3_r  <= last2_r;

      smag_r   <= smag_nxt;
      neg4_r   <= neg3_r;
      rest4_r  <= rest3_r;
      last4_r  <= last3_r;

      sample_r <= sample_nxt;
      last_r   <= last4_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = sample_r;
  assign out_last   = last_r;

endmodule

### rtl/note_oscillator_with_envelope_core.sv
// top level of the note oscillator with attack/release envelope
//
// usage:
//   in_*   : one beat per sample tick; tdata carries start_row, phase_step,
//            waveform, is_rest and has_decay
//   out_*  : one beat per tick with the signed Q1.15 sample in tdata and
//            tlast high on the last sample of a note row
//   cfg_*  : register writes (row length, attack, release and their
//            reciprocals); cfg_ready is always high, write only while idle
// throughput: one tick per cycle while out_tready is high, set by the
//   back-end pipeline which advances one stage per cycle unless the output
//   stalls; the front end only adds phase and index
// path: an accepted input beat is written into the queue, then passes four
//   pipeline stages and the output register before out_tvalid
// reset (rst_n low, synchronous): phase and sample index go to zero, the
//   queue and pipeline empty, registers take their default values
// stall: when out_tready is low with a beat waiting, the output register and
//   the pipeline hold; the queue keeps accepting until it is full, then
//   in_tready drops
module note_oscillator_with_envelope_core import noe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // [0] start_row, [31:1] phase_step, [33:32] waveform, [34] is_rest,
  // [35] has_decay, upper bits zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [15:0] sample, upper bits zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [ROW_BITS-1:0]   row_samples_r;
  logic [SCALE_BITS-1:0] row_scale_r;
  logic [LEN16_BITS-1:0] attack_samples_r;
  logic [SCALE_BITS-1:0] attack_scale_r;
  logic [LEN16_BITS-1:0] release_samples_r;
  logic [SCALE_BITS-1:0] release_scale_r;
  cfg_t                  cfg;

  logic                  push;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  item_t                 front_item;
  item_t                 head_item;
  logic signed [SAMPLE_BITS-1:0] sample;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_samples_r     <= RST_ROW_SAMPLES;
      row_scale_r       <= RST_ROW_SCALE;
      attack_samples_r  <= RST_ATTACK_SAMPLES;
      attack_scale_r    <= RST_ATTACK_SCALE;
      release_samples_r <= RST_RELEASE_SAMPLES;
      release_scale_r   <= RST_RELEASE_SCALE;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_ROW_SAMPLES:     row_samples_r     <= cfg_data[ROW_BITS-1:0];
        CFG_ROW_SCALE:       row_scale_r       <= cfg_data[SCALE_BITS-1:0];
        CFG_ATTACK_SAMPLES:  attack_samples_r  <= cfg_data[LEN16_BITS-1:0];
        CFG_ATTACK_SCALE:    attack_scale_r    <= cfg_data[SCALE_BITS-1:0];
        CFG_RELEASE_SAMPLES: release_samples_r <= cfg_data[LEN16_BITS-1:0];
        CFG_RELEASE_SCALE:   release_scale_r   <= cfg_data[SCALE_BITS-1:0];
        default: ; // unused addresses are ignored
      endcase
    end
  end

  // a zero row length behaves as a one-sample row
  always_comb begin
    cfg.row_len         = (row_samples_r == '0) ? ROW_BITS'(1) : row_samples_r;
    cfg.row_scale       = row_scale_r;
    cfg.attack_samples  = attack_samples_r;
    cfg.attack_scale    = attack_scale_r;
    cfg.release_samples = release_samples_r;
    cfg.release_scale   = release_scale_r;
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  noe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .push       (push),
    .start_row  (in_tdata[0]),
    .phase_step (in_tdata[STEP_BITS:1]),
    .waveform   (wave_t'(in_tdata[STEP_BITS+2:STEP_BITS+1])),
    .is_rest    (in_tdata[STEP_BITS+3]),
    .has_decay  (in_tdata[STEP_BITS+4]),
    .item       (front_item)
  );

  noe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  noe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (sample),
    .out_last   (out_tlast)
  );

  // sample in the low bits, zero padding above
  assign out_tdata = OUT_TDATA_W'($unsigned(sample));

endmodule

### rtl/noe_checker.sv
// port-level checks for the note oscillator core, bound to the top level
module noe_checker import noe_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic                   cfg_ready
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high right after reset");

  // reset empties the queue, so input is taken at once
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("in_tready low right after reset");

  // a stalled beat holds its sample and row flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output beat changed");

  // register writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("cfg_ready dropped");

endmodule

bind note_oscillator_with_envelope_core noe_checker u_noe_checker (.*);
